// ----- hw/rtl/snr_noise_mixer_macros.svh -----
// Assertion macros shared by the noise mixer RTL.
`ifndef SNR_NOISE_MIXER_MACROS_SVH
`define SNR_NOISE_MIXER_MACROS_SVH
`ifndef SYNTHESIS
`define SNR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SNR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SNR_ASSERT(lbl, prop, msg)
`define SNR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/snr_pkg.sv -----
// Types, constants and tables of the noise mixer.
`timescale 1ns / 1ps
package snr_pkg;

  localparam int FracBits  = 16;
  localparam int AccW      = 51;
  localparam int KW        = 88;
  localparam int TW        = 154;
  localparam int RhsW      = 106;
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_MIX     = 1'b1;

  localparam logic [1:0] CFG_SNR_DB    = 2'd0;
  localparam logic [1:0] CFG_NOISE_ENA = 2'd1;

  localparam logic signed [6:0] SNR_MIN   = -7'sd10;
  localparam logic signed [6:0] SNR_MAX   = 7'sd40;
  localparam logic signed [6:0] SNR_RESET = 7'sd10;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] signal_sample;
    logic signed [15:0] noise_sample;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] mixed_sample;
    logic               clipped;
    logic               last_out;
  } out_word_t;

  typedef struct packed {
    logic            start;
    logic [AccW-1:0] es;
    logic [AccW-1:0] en;
  } gain_req_t;

  typedef struct packed {
    logic pop;
    logic out_load;
    logic gain_busy;
  } back_stat_t;

  function automatic logic [19:0] pow_tab(input logic [3:0] idx);
    logic [19:0] v;
    case (idx)
      4'd0:    v = 20'd65536;
      4'd1:    v = 20'd82505;
      4'd2:    v = 20'd103868;
      4'd3:    v = 20'd130762;
      4'd4:    v = 20'd164619;
      4'd5:    v = 20'd207243;
      4'd6:    v = 20'd260904;
      4'd7:    v = 20'd328458;
      4'd8:    v = 20'd413504;
      4'd9:    v = 20'd520571;
      default: v = 20'd65536;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/snr_fifo.sv -----
// Short queue that decouples the input side from the processing back end.
`timescale 1ns / 1ps
module snr_fifo
  import snr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_i,
  output logic     deq_valid_o,
  output in_word_t deq_word_o,
  input  logic     deq_pop_i
);

  in_word_t             mem_q [FifoDepth];
  logic     [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic     [CntW-1:0]  cnt_q, cnt_d;
  logic                 push;

  assign in_stall_o  = (cnt_q == CntW'(FifoDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign deq_valid_o = (cnt_q != '0);
  assign deq_word_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = deq_pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CntW'(push) - CntW'(deq_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_i;
    end
  end

endmodule

// ----- hw/rtl/snr_gain.sv -----
// Sequential noise gain unit: shift-add scaling and a bitwise square root search.
`timescale 1ns / 1ps
module snr_gain
  import snr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gain_req_t          req_i,
  input  logic signed [6:0]  snr_db_i,
  output logic               busy_o,
  output logic [31:0]        gain_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_CMP  = 2'd3;

  logic [1:0]      state_q;
  logic [31:0]     gain_q;
  logic [KW-1:0]   mc_q, acc_q;
  logic [19:0]     mr_q;
  logic [2:0]      phase_q, nmul_q;
  logic [3:0]      r_q;
  logic [RhsW-1:0] rhs_q;
  logic [TW-1:0]   a_q, b_q, p_q, t_q;
  logic [31:0]     g_q;
  logic [4:0]      bit_q;

  logic signed [6:0] dc;
  logic [2:0]        nq;
  logic [3:0]        rr;
  logic              qneg;
  logic [57:0]       es_scaled;
  logic [2:0]        phase_nx;
  logic [19:0]       factor_nx;
  logic              fits;
  logic [TW-1:0]     b_sum;

  assign busy_o = (state_q != ST_IDLE);
  assign gain_o = gain_q;

  always_comb begin
    if (snr_db_i < SNR_MIN) begin
      dc = SNR_MIN;
    end else if (snr_db_i > SNR_MAX) begin
      dc = SNR_MAX;
    end else begin
      dc = snr_db_i;
    end
    qneg = dc[6];
    if (dc >= 7'sd40) begin
      nq = 3'd4;
    end else if (dc >= 7'sd30) begin
      nq = 3'd3;
    end else if (dc >= 7'sd20) begin
      nq = 3'd2;
    end else if (dc >= 7'sd10) begin
      nq = 3'd1;
    end else begin
      nq = 3'd0;
    end
    if (qneg) begin
      nq = 3'd0;
      rr = 4'(dc + 7'sd10);
    end else begin
      rr = 4'(dc - 7'(nq) * 7'sd10);
    end
    if (qneg) begin
      es_scaled = (58'(req_i.es) << 6) + (58'(req_i.es) << 5) + (58'(req_i.es) << 2);
    end else begin
      es_scaled = (58'(req_i.es) << 3) + (58'(req_i.es) << 1);
    end
    phase_nx = phase_q + 3'd1;
    if (phase_nx == 3'd1) begin
      factor_nx = pow_tab(r_q);
    end else begin
      factor_nx = 20'd10;
    end
    fits  = (t_q <= TW'(rhs_q));
    b_sum = fits ? b_q + (a_q << 1) : b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gain_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (req_i.start) begin
            if (req_i.en == '0) begin
              gain_q <= '0;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (mr_q == '0 && phase_nx == nmul_q) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (bit_q == '0) begin
            state_q <= ST_IDLE;
            gain_q  <= fits ? (g_q | 32'd1) : g_q;
          end else begin
            state_q <= ST_SUM;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        mc_q    <= KW'(req_i.en);
        mr_q    <= 20'd11;
        acc_q   <= '0;
        phase_q <= '0;
        nmul_q  <= 3'd2 + nq;
        r_q     <= rr;
        rhs_q   <= RhsW'(es_scaled) << (2 * FracBits + 16);
      end
      ST_MUL: begin
        if (mr_q != '0) begin
          if (mr_q[0]) begin
            acc_q <= acc_q + mc_q;
          end
          mc_q <= mc_q << 1;
          mr_q <= mr_q >> 1;
        end else begin
          phase_q <= phase_nx;
          mc_q    <= acc_q;
          mr_q    <= factor_nx;
          acc_q   <= '0;
          a_q     <= TW'(acc_q) << 62;
          b_q     <= '0;
          p_q     <= '0;
          g_q     <= '0;
          bit_q   <= 5'd31;
        end
      end
      ST_SUM: begin
        t_q <= p_q + b_q + a_q;
      end
      ST_CMP: begin
        if (fits) begin
          p_q <= t_q;
          g_q <= g_q | (32'd1 << bit_q);
        end
        b_q   <= b_sum >> 1;
        a_q   <= a_q >> 2;
        bit_q <= bit_q - 5'd1;
      end
      default: begin
        t_q <= t_q;
      end
    endcase
  end

endmodule

// ----- hw/rtl/snr_back.sv -----
// Back end: energy accumulation, gain update and the mixing output stage.
`timescale 1ns / 1ps
module snr_back
  import snr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              deq_valid_i,
  input  in_word_t          deq_word_i,
  output logic              deq_pop_o,
  input  logic signed [6:0] snr_db_i,
  input  logic              noise_enable_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_o,
  output back_stat_t        stat_o
);

  logic [AccW-1:0] es_q, es_d, en_q, en_d;
  logic            out_valid_q;
  out_word_t       out_q, out_d;
  gain_req_t       req;
  logic            busy;
  logic [31:0]     gain;
  logic            out_free, out_load, measure;
  logic [31:0]     sq_s, sq_n;
  logic [AccW:0]   sum_s, sum_n;
  logic signed [48:0] prod;
  logic signed [49:0] total, adj;
  logic signed [49:0] hi_lim, lo_lim;

  snr_gain u_gain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .snr_db_i (snr_db_i),
    .busy_o   (busy),
    .gain_o   (gain)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign measure   = (deq_word_i.opcode == OP_MEASURE);
  assign deq_pop_o = deq_valid_i && !busy && (measure || out_free);
  assign out_load  = deq_pop_o && !measure;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign stat_o      = '{pop: deq_pop_o, out_load: out_load, gain_busy: busy};

  always_comb begin
    sq_s  = 32'(deq_word_i.signal_sample * deq_word_i.signal_sample);
    sq_n  = 32'(deq_word_i.noise_sample * deq_word_i.noise_sample);
    sum_s = (AccW + 1)'(es_q) + (AccW + 1)'(sq_s);
    sum_n = (AccW + 1)'(en_q) + (AccW + 1)'(sq_n);
    es_d  = sum_s[AccW] ? '1 : sum_s[AccW-1:0];
    en_d  = sum_n[AccW] ? '1 : sum_n[AccW-1:0];
    req.start = deq_pop_o && measure && deq_word_i.last;
    req.es    = es_d;
    req.en    = en_d;

    prod   = deq_word_i.noise_sample * $signed({1'b0, gain});
    total  = (50'(deq_word_i.signal_sample) <<< FracBits) + 50'(prod);
    hi_lim = 50'sd32767 <<< FracBits;
    lo_lim = -(50'sd32768 <<< FracBits);
    adj    = total + (total[49] ? 50'sd65535 : 50'sd0);
    out_d.last_out = deq_word_i.last;
    out_d.clipped  = 1'b0;
    if (!noise_enable_i) begin
      out_d.mixed_sample = deq_word_i.signal_sample;
    end else if (total > hi_lim) begin
      out_d.mixed_sample = 16'sd32767;
      out_d.clipped      = 1'b1;
    end else if (total < lo_lim) begin
      out_d.mixed_sample = -16'sd32768;
      out_d.clipped      = 1'b1;
    end else begin
      out_d.mixed_sample = 16'(adj >>> FracBits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      es_q        <= '0;
      en_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (deq_pop_o && measure) begin
        es_q <= deq_word_i.last ? '0 : es_d;
        en_q <= deq_word_i.last ? '0 : en_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- hw/rtl/snr_noise_mixer.sv -----
// Noise mixer at a target SNR: input queue, back end and configuration registers.
// Mix words are registered at the output; one per cycle unless stalled or gain busy.
// A measure word adds to the energy sums; the last one starts the gain unit in the back end.
// The gain unit runs shift-add scaling and then a bitwise square root search.
// The back end holds the queue during that time. Reset is asynchronous and active low.
// Reset clears energies and gain, sets snr_db to 10 and noise mixing on.
`timescale 1ns / 1ps
`include "snr_noise_mixer_macros.svh"
module snr_noise_mixer
  import snr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);

  logic signed [6:0] snr_db_q;
  logic              noise_enable_q;
  logic              deq_valid, deq_pop;
  in_word_t          deq_word;
  back_stat_t        stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snr_db_q       <= SNR_RESET;
      noise_enable_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SNR_DB:    snr_db_q       <= cfg_data_i;
        CFG_NOISE_ENA: noise_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  snr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .deq_valid_o (deq_valid),
    .deq_word_o  (deq_word),
    .deq_pop_i   (deq_pop)
  );

  snr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .deq_valid_i    (deq_valid),
    .deq_word_i     (deq_word),
    .deq_pop_o      (deq_pop),
    .snr_db_i       (snr_db_q),
    .noise_enable_i (noise_enable_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_o          (out_o),
    .stat_o         (stat)
  );

  `SNR_ASSERT(a_no_pop_busy, stat.gain_busy |-> !stat.pop, "queue popped while gain busy")
  `SNR_ASSERT(a_load_valid, stat.out_load |=> out_valid_o, "loaded word not presented")
  `SNR_ASSERT(a_bypass_noclip, (stat.out_load && !noise_enable_q) |=> !out_o.clipped, "clip in bypass")
  `SNR_ASSERT_ALWAYS(a_pop_has_word, stat.pop |-> deq_valid, "pop from empty queue")

endmodule

// ----- sim/tb_snr_noise_mixer.sv -----
// Self-checking testbench for the noise mixer: random streams with a cycle-free gain predictor.
`timescale 1ns / 1ps
module tb_snr_noise_mixer
  import snr_pkg::*;
();

  localparam int GainWait = 700;
  localparam logic [19:0] DB_STEP [10] = '{20'd65536, 20'd82505, 20'd103868, 20'd130762,
    20'd164619, 20'd207243, 20'd260904, 20'd328458, 20'd413504, 20'd520571};
  localparam logic [50:0] ENERGY_MAX = {51{1'b1}};

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_SNR_DB;
  logic [6:0] cfg_data = '0;

  in_word_t  pending_words[$];
  out_word_t expected_samples[$];
  logic [50:0] sig_energy = '0;
  logic [50:0] noise_acc = '0;
  logic [31:0] beta = '0;
  logic [6:0]  snr_setting = SNR_RESET;
  logic        mix_on = 1'b1;
  bit  calm = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;
  int  errors = 0;
  int  words_in = 0;
  int  words_out = 0;
  int  gains_set = 0;

  snr_noise_mixer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [50:0] add_energy(logic [50:0] acc, logic signed [15:0] x);
    logic [51:0] total;
    total = {1'b0, acc} + 52'(longint'(x) * longint'(x));
    return total > {1'b0, ENERGY_MAX} ? ENERGY_MAX : total[50:0];
  endfunction

  function automatic logic [31:0] noise_gain_for(logic [50:0] es, logic [50:0] en,
                                                 logic [6:0] snr);
    logic [159:0] rhs;
    logic [159:0] lhs;
    logic [31:0]  g;
    logic [31:0]  c;
    int d;
    int q;
    int r;
    if (en == '0) return '0;
    d = int'($signed(snr));
    if (d < -10) d = -10;
    if (d > 40) d = 40;
    if (d < 0) begin
      q = -1;
      r = d + 10;
    end else begin
      q = d / 10;
      r = d % 10;
    end
    rhs = 160'(es) * 160'd10;
    if (q < 0) rhs = rhs * 160'd10;
    rhs = rhs << (2 * FracBits + 16);
    g = '0;
    for (int b = 31; b >= 0; b--) begin
      c = g | (32'd1 << b);
      lhs = 160'(en) * 160'(c) * 160'(c) * 160'd11 * 160'(DB_STEP[r]);
      for (int i = 0; i < q; i++) lhs = lhs * 160'd10;
      if (lhs <= rhs) g = c;
    end
    return g;
  endfunction

  task automatic predict_word(in_word_t w);
    out_word_t o;
    longint total;
    longint one;
    if (w.opcode == OP_MEASURE) begin
      sig_energy = add_energy(sig_energy, w.signal_sample);
      noise_acc  = add_energy(noise_acc, w.noise_sample);
      if (w.last) begin
        beta = noise_gain_for(sig_energy, noise_acc, snr_setting);
        sig_energy = '0;
        noise_acc = '0;
        gains_set++;
      end
      return;
    end
    o = '0;
    o.last_out = w.last;
    if (!mix_on) begin
      o.mixed_sample = w.signal_sample;
    end else begin
      one = longint'(1) << FracBits;
      total = longint'(w.signal_sample) * one + longint'(w.noise_sample) * longint'({32'd0, beta});
      if (total > 32767 * one) begin
        o.mixed_sample = 16'sh7fff;
        o.clipped = 1'b1;
      end else if (total < -32768 * one) begin
        o.mixed_sample = 16'sh8000;
        o.clipped = 1'b1;
      end else if (total < 0) begin
        o.mixed_sample = 16'(-((-total) >>> FracBits));
      end else begin
        o.mixed_sample = 16'(total >>> FracBits);
      end
    end
    expected_samples.push_back(o);
  endtask

  task automatic report_mismatch(string what, int want, int got);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    errors++;
  endtask

  // Input driver: payload only changes when no word is held under stall.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        predict_word(in_word);
        words_in++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          in_word <= pending_words.pop_front();
          if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and receiver stall generator.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        words_out++;
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected word, sample", 0, int'(out_word.mixed_sample));
        end else begin
          out_word_t e;
          e = expected_samples.pop_front();
          if (out_word.mixed_sample !== e.mixed_sample)
            report_mismatch("mixed_sample", int'(e.mixed_sample), int'(out_word.mixed_sample));
          if (out_word.clipped !== e.clipped)
            report_mismatch("clipped", int'(e.clipped), int'(out_word.clipped));
          if (out_word.last_out !== e.last_out)
            report_mismatch("last_out", int'(e.last_out), int'(out_word.last_out));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [6:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CFG_SNR_DB) snr_setting = value;
    else mix_on = value[0];
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (pending_words.size() == 0 && !in_valid && expected_samples.size() == 0);
    repeat (GainWait) @(posedge clk_i);
  endtask

  task automatic push_word(logic op, logic [15:0] s, logic [15:0] n, logic lst);
    in_word_t w;
    w.opcode = op;
    w.signal_sample = s;
    w.noise_sample = n;
    w.last = lst;
    pending_words.push_back(w);
  endtask

  // A measure pass over random pairs followed by a mix pass over the same pairs.
  task automatic push_utterance(int len);
    logic [15:0] s[$];
    logic [15:0] n[$];
    int shift;
    shift = $urandom_range(0, 14);
    for (int i = 0; i < len; i++) begin
      s.push_back(16'($urandom));
      n.push_back(16'($signed(16'($urandom)) >>> shift));
      if ($urandom_range(0, 9) == 0) n[i] = '0;
    end
    if ($urandom_range(0, 7) == 0) foreach (n[i]) n[i] = '0;
    for (int i = 0; i < len; i++) push_word(OP_MEASURE, s[i], n[i], i == len - 1);
    for (int i = 0; i < len; i++) push_word(OP_MIX, s[i], n[i], i == len - 1);
  endtask

  task automatic push_noise(int count);
    for (int i = 0; i < count; i++)
      push_word(1'($urandom), 16'($urandom), 16'($urandom), $urandom_range(0, 9) == 0);
  endtask

  initial begin
    logic [6:0] snr_plan[8];
    snr_plan = '{7'd0, 7'h76, 7'd40, 7'd63, 7'h40, 7'd25, 7'h7b, 7'd7};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: mix with zero gain, extreme pairs, silent noise, strong noise.
    push_word(OP_MIX, 16'h7fff, 16'h8000, 1'b0);
    push_word(OP_MIX, 16'h8000, 16'h7fff, 1'b1);
    push_word(OP_MEASURE, 16'h7fff, 16'h0000, 1'b0);
    push_word(OP_MEASURE, 16'h8000, 16'h0000, 1'b1);
    push_word(OP_MIX, 16'h1234, 16'h7fff, 1'b1);
    push_word(OP_MEASURE, 16'h8000, 16'h0001, 1'b1);
    push_word(OP_MIX, 16'h7fff, 16'h7fff, 1'b0);
    push_word(OP_MIX, 16'h8000, 16'h8000, 1'b0);
    push_word(OP_MIX, 16'h0000, 16'hffff, 1'b0);
    push_word(OP_MIX, 16'h0000, 16'h0001, 1'b1);
    push_word(OP_MEASURE, 16'h0001, 16'h8000, 1'b0);
    push_word(OP_MEASURE, 16'h0000, 16'h7fff, 1'b1);
    push_word(OP_MIX, 16'h7fff, 16'h8000, 1'b0);
    push_word(OP_MIX, 16'hfffe, 16'h0003, 1'b1);
    wait_idle();
    write_reg(CFG_NOISE_ENA, 7'd0);
    write_reg(CFG_SNR_DB, 7'h76);
    push_word(OP_MEASURE, 16'h4000, 16'h0010, 1'b1);
    push_word(OP_MIX, 16'h8000, 16'h7fff, 1'b0);
    push_word(OP_MIX, 16'h7fff, 16'h7fff, 1'b1);
    wait_idle();
    write_reg(CFG_NOISE_ENA, 7'd1);
    push_word(OP_MIX, 16'h4000, 16'h7fff, 1'b0);
    push_word(OP_MIX, 16'hc000, 16'h8000, 1'b1);
    wait_idle();

    foreach (snr_plan[p]) begin
      write_reg(CFG_SNR_DB, snr_plan[p]);
      if (p == 5) write_reg(CFG_NOISE_ENA, 7'd0);
      if (p == 6) write_reg(CFG_NOISE_ENA, 7'd1);
      if (p == 7) calm = 1'b1;
      repeat (6) push_utterance($urandom_range(1, 10));
      push_noise(8);
      wait_idle();
    end

    $display("Covered %0d words in, %0d words out, %0d gain updates, %0d SNR settings.",
             words_in, words_out, gains_set, $size(snr_plan) + 1);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d words still expected.", expected_samples.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
